### sv/a85_pkg.sv
package a85_pkg;

  // Character codes
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Base-85 weights for one, two and three padding digits
  localparam logic [19:0] POW85_1 = 20'd85;
  localparam logic [19:0] POW85_2 = 20'd7225;
  localparam logic [19:0] POW85_3 = 20'd614125;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_START = 3'd0,
    ERR_BAD_END   = 3'd1,
    ERR_BAD_CHAR  = 3'd2,
    ERR_TRAILING  = 3'd3,
    ERR_OVERFLOW  = 3'd4,
    ERR_LONE      = 3'd5
  } err_t;

  // What follows the data bytes of a result group
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_DONE = 2'd1,
    TAIL_ERR  = 2'd2
  } tail_t;

  // One group of results: nbytes bytes from the top of word, then the tail
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    tail_t       tail;
    err_t        code;
  } grp_t;

endpackage

### sv/ascii85_stream_decoder.sv
// Channel  Dir  tdata                              tuser      tlast
// s_*      in   [7:0] in_char                      -          end_of_input
// m_*      out  [7:0] out_byte, [10:8] error_code  [1:0] kind last
//
// One character is taken per cycle into an input register; the base-85 step
// (one 32x20 multiply-add) and the result group are settled before the next edge.
// A character that causes results waits in the input register until the group
// before it has fully drained (up to four transfers, one result per transfer);
// characters with no result retire even while results wait.
// Synchronous active-high reset returns to awaiting the opening delimiter.
// Stalls on m_tready back up into s_tready; nothing is dropped.
module ascii85_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);
  import a85_pkg::*;

  logic grp_valid;
  logic grp_free;
  grp_t grp;

  a85_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .grp_free  (grp_free),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  a85_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_free  (grp_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

### sv/a85_decode.sv
module a85_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tlast,
  input  logic          grp_free,
  output logic          grp_valid,
  output a85_pkg::grp_t grp
);
  import a85_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT_LT = 3'd0,
    PH_WAIT_TL = 3'd1,
    PH_BODY    = 3'd2,
    PH_TILDE   = 3'd3,
    PH_CLOSED  = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] tuple_value, tuple_next;
  logic [2:0]  digit_count, digit_count_next;
  logic        in_valid;
  logic [7:0]  in_char;
  logic        in_eoi;

  logic        emit;
  logic        consume;
  logic        is_space;
  logic        is_digit;
  logic [6:0]  digit;
  logic [19:0] mul_k;
  logic [19:0] add_k;
  logic [51:0] prod;
  logic [51:0] sum;
  logic        ovf;

  // Shared multiply-add: digit step in the body, padding at end of input
  always_comb begin
    unique case (digit_count)
      3'd2:    mul_k = POW85_3;
      3'd3:    mul_k = POW85_2;
      default: mul_k = POW85_1;
    endcase
    if (!in_eoi) begin
      mul_k = POW85_1;
    end
  end

  assign digit    = 7'(in_char - CH_BANG);
  assign add_k    = in_eoi ? (mul_k - 20'd1) : {13'd0, digit};
  assign prod     = tuple_value * mul_k;
  assign sum      = prod + {32'd0, add_k};
  assign ovf      = |sum[51:32];
  assign is_space = (in_char == CH_SP) || (in_char == CH_TAB) || (in_char == CH_NL);
  assign is_digit = (in_char >= CH_BANG) && (in_char <= CH_U);

  // Next state and result group for the held character
  always_comb begin
    phase_next       = phase;
    tuple_next       = tuple_value;
    digit_count_next = digit_count;
    emit             = 1'b0;
    grp.word         = sum[31:0];
    grp.nbytes       = 3'd0;
    grp.tail         = TAIL_NONE;
    grp.code         = ERR_BAD_START;
    if (in_eoi) begin
      unique case (phase)
        PH_WAIT_LT, PH_WAIT_TL: begin
          emit = 1'b1; grp.tail = TAIL_ERR; grp.code = ERR_BAD_START;
          phase_next = PH_ERROR;
        end
        PH_BODY: begin
          emit = 1'b1; grp.tail = TAIL_ERR; grp.code = ERR_BAD_END;
          phase_next = PH_ERROR;
        end
        PH_TILDE: begin
          emit = 1'b1; grp.tail = TAIL_ERR; grp.code = ERR_BAD_CHAR;
          phase_next = PH_ERROR;
        end
        PH_CLOSED: begin
          emit = 1'b1;
          if (digit_count == 3'd1) begin
            grp.tail = TAIL_ERR; grp.code = ERR_LONE;
            phase_next = PH_ERROR;
          end else if (digit_count != 3'd0 && ovf) begin
            grp.tail = TAIL_ERR; grp.code = ERR_OVERFLOW;
            phase_next = PH_ERROR;
          end else begin
            if (digit_count != 3'd0) begin
              grp.nbytes = digit_count - 3'd1;
            end
            grp.tail         = TAIL_DONE;
            phase_next       = PH_DONE;
            tuple_next       = 32'd0;
            digit_count_next = 3'd0;
          end
        end
        default: ;
      endcase
    end else begin
      unique case (phase)
        PH_WAIT_LT: begin
          if (in_char == CH_LT) begin
            phase_next = PH_WAIT_TL;
          end else if (!is_space) begin
            emit = 1'b1; grp.tail = TAIL_ERR; grp.code = ERR_BAD_START;
            phase_next = PH_ERROR;
          end
        end
        PH_WAIT_TL: begin
          if (in_char == CH_TILDE) begin
            phase_next = PH_BODY;
          end else begin
            emit = 1'b1; grp.tail = TAIL_ERR; grp.code = ERR_BAD_START;
            phase_next = PH_ERROR;
          end
        end
        PH_BODY: begin
          if (is_space) begin
            phase_next = PH_BODY;
          end else if (in_char == CH_Z) begin
            emit = 1'b1;
            if (digit_count != 3'd0) begin
              grp.tail = TAIL_ERR; grp.code = ERR_BAD_CHAR;
              phase_next = PH_ERROR;
            end else begin
              grp.word = 32'd0; grp.nbytes = 3'd4;
            end
          end else if (in_char == CH_TILDE) begin
            phase_next = PH_TILDE;
          end else if (!is_digit) begin
            emit = 1'b1; grp.tail = TAIL_ERR; grp.code = ERR_BAD_CHAR;
            phase_next = PH_ERROR;
          end else if (ovf) begin
            emit = 1'b1; grp.tail = TAIL_ERR; grp.code = ERR_OVERFLOW;
            phase_next = PH_ERROR;
          end else if (digit_count == 3'd4) begin
            emit = 1'b1; grp.nbytes = 3'd4;
            tuple_next       = 32'd0;
            digit_count_next = 3'd0;
          end else begin
            tuple_next       = sum[31:0];
            digit_count_next = digit_count + 3'd1;
          end
        end
        PH_TILDE: begin
          if (in_char == CH_GT) begin
            phase_next = PH_CLOSED;
          end else begin
            emit = 1'b1; grp.tail = TAIL_ERR; grp.code = ERR_BAD_CHAR;
            phase_next = PH_ERROR;
          end
        end
        PH_CLOSED: begin
          if (!is_space) begin
            emit = 1'b1; grp.tail = TAIL_ERR; grp.code = ERR_TRAILING;
            phase_next = PH_ERROR;
          end
        end
        default: ;
      endcase
    end
  end

  // Items without results retire at once; others wait for a free group slot
  assign consume   = in_valid && (grp_free || !emit);
  assign grp_valid = in_valid && emit && grp_free;
  assign s_tready  = !in_valid || consume;

  // Hold the input item and the decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      phase       <= PH_WAIT_LT;
      tuple_value <= 32'd0;
      digit_count <= 3'd0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (consume) begin
        in_valid <= 1'b0;
      end
      if (consume) begin
        phase       <= phase_next;
        tuple_value <= tuple_next;
        digit_count <= digit_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_eoi  <= s_tlast;
    end
  end

  a_dcnt_range: assert property (@(posedge clk) disable iff (rst)
    digit_count <= 3'd4)
    else $error("digit count above four");

  a_grp_from_item: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> (in_valid && grp_free))
    else $error("result group without a held item");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERROR) |=> (phase == PH_ERROR))
    else $error("error state left before reset");

endmodule

### sv/a85_serial.sv
module a85_serial (
  input  logic          clk,
  input  logic          rst,
  input  logic          grp_valid,
  input  a85_pkg::grp_t grp,
  output logic          grp_free,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  output logic [1:0]    m_tuser,
  output logic          m_tlast
);
  import a85_pkg::*;

  logic [31:0] word;
  logic [2:0]  nbytes;
  tail_t       tail;
  err_t        code;
  logic        xfer;
  kind_t       kind;
  logic [7:0]  out_byte;
  logic [2:0]  out_code;

  assign m_tvalid = (nbytes != 3'd0) || (tail != TAIL_NONE);
  assign m_tlast  = (nbytes == 3'd0) || ((nbytes == 3'd1) && (tail == TAIL_NONE));
  assign xfer     = m_tvalid && m_tready;
  assign grp_free = !m_tvalid || (xfer && m_tlast);

  // Select the current result: bytes first, then the tail
  always_comb begin
    if (nbytes != 3'd0) begin
      kind     = KIND_BYTE;
      out_byte = word[31:24];
      out_code = 3'd0;
    end else if (tail == TAIL_ERR) begin
      kind     = KIND_ERR;
      out_byte = 8'd0;
      out_code = code;
    end else begin
      kind     = KIND_DONE;
      out_byte = 8'd0;
      out_code = 3'd0;
    end
  end

  assign m_tdata = {5'd0, out_code, out_byte};
  assign m_tuser = kind;

  // Load a new group or advance one result per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      nbytes <= 3'd0;
      tail   <= TAIL_NONE;
    end else if (grp_valid) begin
      nbytes <= grp.nbytes;
      tail   <= grp.tail;
    end else if (xfer) begin
      if (nbytes != 3'd0) begin
        nbytes <= nbytes - 3'd1;
      end else begin
        tail <= TAIL_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid) begin
      word <= grp.word;
      code <= grp.code;
    end else if (xfer && nbytes != 3'd0) begin
      word <= {word[23:0], 8'd0};
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> grp_free)
    else $error("result group loaded over pending results");

  a_tail_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_BYTE) |-> (m_tdata[7:0] == 8'd0))
    else $error("status result carries a nonzero byte");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (xfer && m_tlast && !grp_valid) |=> !m_tvalid)
    else $error("results left after final transfer of a group");

endmodule
